@@ rtl/core/sge_pkg.sv @@
// ----------------------------------------------------------------------------
// sge_pkg
// Shared constants, command and status codes and the arctangent table
// of the state-vector gate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sge_pkg;

   localparam int SGE_MAX_QUBITS = 10;
   localparam int SGE_AMP_BITS   = 32;

   localparam int COEF_W       = 32;
   localparam int COEF_FRAC    = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_START = 652032874;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type COEF_ONE  = 32'sh4000_0000;
   localparam coef_type COEF_ZERO = 32'sh0000_0000;
   localparam coef_type COEF_HR   = 32'sd759250125;

   localparam logic [4:0] OP_RESET = 5'd0;
   localparam logic [4:0] OP_READ  = 5'd1;
   localparam logic [4:0] OP_H     = 5'd2;
   localparam logic [4:0] OP_X     = 5'd3;
   localparam logic [4:0] OP_Y     = 5'd4;
   localparam logic [4:0] OP_Z     = 5'd5;
   localparam logic [4:0] OP_S     = 5'd6;
   localparam logic [4:0] OP_SDG   = 5'd7;
   localparam logic [4:0] OP_T     = 5'd8;
   localparam logic [4:0] OP_TDG   = 5'd9;
   localparam logic [4:0] OP_CX    = 5'd10;
   localparam logic [4:0] OP_CZ    = 5'd11;
   localparam logic [4:0] OP_SWAP  = 5'd12;
   localparam logic [4:0] OP_CCX   = 5'd13;
   localparam logic [4:0] OP_MCX   = 5'd14;
   localparam logic [4:0] OP_CSWAP = 5'd15;
   localparam logic [4:0] OP_RX    = 5'd16;
   localparam logic [4:0] OP_RY    = 5'd17;
   localparam logic [4:0] OP_RZ    = 5'd18;
   localparam logic [4:0] OP_P     = 5'd19;
   localparam logic [4:0] OP_CRX   = 5'd20;
   localparam logic [4:0] OP_CRY   = 5'd21;
   localparam logic [4:0] OP_CRZ   = 5'd22;
   localparam logic [4:0] OP_CP    = 5'd23;

   localparam logic [1:0] ROT_X = 2'd0;
   localparam logic [1:0] ROT_Y = 2'd1;
   localparam logic [1:0] ROT_Z = 2'd2;
   localparam logic [1:0] ROT_P = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_RESET = 3'd1;
   localparam logic [2:0] ST_RANGE     = 3'd2;
   localparam logic [2:0] ST_REPEAT    = 3'd3;
   localparam logic [2:0] ST_UNSUP     = 3'd4;
   localparam logic [2:0] ST_NO_CTRL   = 3'd5;

   // arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
   function automatic logic [29:0] sge_atan(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:    v = 30'h20000000;
         5'd1:    v = 30'h12E4051E;
         5'd2:    v = 30'h09FB385B;
         5'd3:    v = 30'h051111D4;
         5'd4:    v = 30'h028B0D43;
         5'd5:    v = 30'h0145D7E1;
         5'd6:    v = 30'h00A2F61E;
         5'd7:    v = 30'h00517C55;
         5'd8:    v = 30'h0028BE53;
         5'd9:    v = 30'h00145F2F;
         5'd10:   v = 30'h000A2F98;
         5'd11:   v = 30'h000517CC;
         5'd12:   v = 30'h00028BE6;
         5'd13:   v = 30'h000145F3;
         5'd14:   v = 30'h0000A2FA;
         5'd15:   v = 30'h0000517D;
         5'd16:   v = 30'h000028BE;
         5'd17:   v = 30'h0000145F;
         5'd18:   v = 30'h00000A30;
         5'd19:   v = 30'h00000518;
         5'd20:   v = 30'h0000028C;
         5'd21:   v = 30'h00000146;
         5'd22:   v = 30'h000000A3;
         5'd23:   v = 30'h00000051;
         5'd24:   v = 30'h00000029;
         5'd25:   v = 30'h00000014;
         5'd26:   v = 30'h0000000A;
         5'd27:   v = 30'h00000005;
         5'd28:   v = 30'h00000003;
         5'd29:   v = 30'h00000001;
         default: v = 30'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/sge_amp_ram.sv @@
// ----------------------------------------------------------------------------
// sge_amp_ram
// Amplitude store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sge_amp_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 64
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/sge_cordic.sv @@
// ----------------------------------------------------------------------------
// sge_cordic
// Iterative rotation unit: cosine and sine of a 32-bit turn code,
// one rotation step per cycle, Q1.30 results.
// ----------------------------------------------------------------------------
`default_nettype none

module sge_cordic
   import sge_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] turn,
   output logic             done_ff,
   output coef_type         cos_ff,
   output coef_type         sin_ff
);

   localparam logic signed [33:0] XY_ONE = 34'sd1073741824;

   logic              busy_ff, busy_in;
   logic              done_in;
   logic [4:0]        step_ff, step_in;
   logic [1:0]        quad_ff, quad_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   coef_type          cos_in, sin_in;

   logic signed [33:0] dx, dy, xc, yc;
   logic signed [32:0] at;
   coef_type          xs, ys;

   always_comb begin
      dx = x_ff >>> step_ff;
      dy = y_ff >>> step_ff;
      at = signed'({3'b000, sge_atan(step_ff)});
      xc = (x_ff > XY_ONE) ? XY_ONE : ((x_ff < -XY_ONE) ? -XY_ONE : x_ff);
      yc = (y_ff > XY_ONE) ? XY_ONE : ((y_ff < -XY_ONE) ? -XY_ONE : y_ff);
      xs = coef_type'(xc);
      ys = coef_type'(yc);

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quad_in = quad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quad_in = turn[31:30];
         x_in    = 34'(CORDIC_START);
         y_in    = '0;
         z_in    = signed'({3'b000, turn[29:0]});
      end else if (busy_ff) begin
         if (step_ff == 5'(CORDIC_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            case (quad_ff)
               2'd0: begin cos_in = xs;  sin_in = ys;  end
               2'd1: begin cos_in = -ys; sin_in = xs;  end
               2'd2: begin cos_in = -xs; sin_in = -ys; end
               default: begin cos_in = ys; sin_in = -xs; end
            endcase
         end else begin
            step_in = step_ff + 5'd1;
            if (!z_ff[32]) begin
               x_in = x_ff - dy;
               y_in = y_ff + dx;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dy;
               y_in = y_ff - dx;
               z_in = z_ff + at;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/sge_mix.sv @@
// ----------------------------------------------------------------------------
// sge_mix
// Two-stage dot product of four coefficients and four amplitudes,
// rounded half up to the amplitude grid and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module sge_mix
   import sge_pkg::*;
#(
   parameter int AMP_BITS = SGE_AMP_BITS
) (
   input  wire logic                       clock,
   input  wire coef_type                   coef [4],
   input  wire logic signed [AMP_BITS-1:0] opr [4],
   output logic signed [AMP_BITS-1:0]      res_ff
);

   localparam int PW = COEF_W + AMP_BITS;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] AMAX = SW'((64'sd1 <<< (AMP_BITS - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] AMIN = -AMAX - SW'(1);
   localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (COEF_FRAC - 1));

   logic signed [PW-1:0] prod_ff [4];
   logic signed [SW-1:0] sum, sh;
   logic signed [AMP_BITS-1:0] res_in;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         prod_ff[i] <= PW'(coef[i]) * PW'(opr[i]);
      end
   end

   always_comb begin
      sum = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]) + SW'(prod_ff[3]);
      sh  = (sum + HALF) >>> COEF_FRAC;
      if (sh > AMAX) begin
         res_in = AMP_BITS'(AMAX);
      end else if (sh < AMIN) begin
         res_in = AMP_BITS'(AMIN);
      end else begin
         res_in = AMP_BITS'(sh);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/statevector_gate_engine.sv @@
// ----------------------------------------------------------------------------
// statevector_gate_engine
// State-vector gate engine: amplitude memory, rotation unit, pair sequencer, mix unit.
// ----------------------------------------------------------------------------
// One command is in work at a time; a new one is taken while the previous
// result still waits on the rsp side. With n qubits in use, a gate scans all
// 2^n indices of the amplitude memory (one write port, one read port); each
// visited pair takes two reads, four components through the two-stage mix
// unit and two writes, and controlled gates visit fewer pairs. Rotation and
// phase gates first run the iterative sine/cosine unit. A reset command is a
// clearing pass over the 2^n entries; a read passes through a wait and a
// capture state; a command rejected with an error status goes straight to
// the response state. Writing qubit_count requires a following reset command.
// ----------------------------------------------------------------------------
`default_nettype none

module statevector_gate_engine
   import sge_pkg::*;
#(
   parameter int MAX_QUBITS = SGE_MAX_QUBITS,
   parameter int AMP_BITS   = SGE_AMP_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [4:0]  req_op,
   input  wire logic [3:0]  req_qubit_a,
   input  wire logic [3:0]  req_qubit_b,
   input  wire logic [3:0]  req_qubit_c,
   input  wire logic [9:0]  req_control_set,
   input  wire logic [31:0] req_angle,
   input  wire logic [9:0]  req_amp_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic signed [31:0] rsp_amp_real,
   output logic signed [31:0] rsp_amp_imag,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data
);

   localparam int ADDR_W = MAX_QUBITS;
   localparam int NW     = $clog2(MAX_QUBITS + 1);
   localparam int DW     = 2 * AMP_BITS;
   localparam logic signed [AMP_BITS-1:0] AMP_ONE = AMP_BITS'(1) << (AMP_BITS - 2);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_RDWAIT = 4'd2;
   localparam logic [3:0] S_RDCAP  = 4'd3;
   localparam logic [3:0] S_TRIG   = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_RDJ    = 4'd6;
   localparam logic [3:0] S_LDJ    = 4'd7;
   localparam logic [3:0] S_MIX    = 4'd8;
   localparam logic [3:0] S_WRK    = 4'd9;
   localparam logic [3:0] S_WRJ    = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W:0]   k_ff, k_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [4:0]        op_ff, op_in;
   logic [9:0]        aidx_ff, aidx_in;
   logic [2:0]        status_ff, status_in;
   logic              ready_ff, ready_in;
   logic [3:0]        qcount_ff, qcount_in;
   logic [ADDR_W-1:0] ctrl_ff, ctrl_in, zmask_ff, zmask_in;
   logic [ADDR_W-1:0] omask_ff, omask_in, flip_ff, flip_in;
   coef_type          cre_ff [4], cre_in [4], cim_ff [4], cim_in [4];
   logic [DW-1:0]     a0_ff, a0_in, a1_ff, a1_in;
   logic signed [AMP_BITS-1:0] res_ff [4], res_in [4];
   logic signed [AMP_BITS-1:0] out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;

   logic [NW-1:0]     n_used;
   logic [ADDR_W:0]   dim;
   logic [ADDR_W-1:0] kq, jq;
   logic              pair_hit;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0]     ram_wdata, ram_rdata;

   logic              cordic_start, cordic_done;
   logic [31:0]       cordic_turn;
   coef_type          cos_v, sin_v;

   coef_type          mix_coef [4];
   logic signed [AMP_BITS-1:0] mix_opr [4];
   logic signed [AMP_BITS-1:0] mix_res;

   // decoded request
   logic [2:0]        chk;
   logic              is_rot;
   logic [ADDR_W-1:0] g_ctrl, g_z, g_o, g_flip, a_bit, b_bit, c_bit, t_bit;
   coef_type          g_re [4], g_im [4];
   logic [1:0]        qcnt;
   logic              use_swap;
   logic              cset_qc;

   logic signed [AMP_BITS-1:0] r0, i0, r1, i1;
   logic [1:0]        row0, row1;

   sge_amp_ram #(.ADDR_W(ADDR_W), .DATA_W(DW)) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   sge_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .turn    (cordic_turn),
      .done_ff (cordic_done),
      .cos_ff  (cos_v),
      .sin_ff  (sin_v)
   );

   sge_mix #(.AMP_BITS(AMP_BITS)) u_mix (
      .clock  (clock),
      .coef   (mix_coef),
      .opr    (mix_opr),
      .res_ff (mix_res)
   );

   // qubit count used, clamped to the supported range
   always_comb begin
      if (qcount_ff == 4'd0) begin
         n_used = NW'(1);
      end else if (32'(qcount_ff) > MAX_QUBITS) begin
         n_used = NW'(MAX_QUBITS);
      end else begin
         n_used = NW'(qcount_ff);
      end
      dim      = (ADDR_W + 1)'(1) << n_used;
      kq       = k_ff[ADDR_W-1:0];
      jq       = kq ^ flip_ff;
      pair_hit = ((kq & ctrl_ff) == ctrl_ff) && ((kq & zmask_ff) == '0) &&
                 ((kq & omask_ff) == omask_ff);
   end

   // request checks and gate setup
   always_comb begin
      a_bit   = ADDR_W'(1) << req_qubit_a;
      b_bit   = ADDR_W'(1) << req_qubit_b;
      c_bit   = ADDR_W'(1) << req_qubit_c;
      cset_qc = (req_qubit_c < 4'd10) ? req_control_set[req_qubit_c] : 1'b0;
      is_rot  = req_op inside {[OP_RX:OP_CP]};
      if (req_op inside {[OP_H:OP_TDG], [OP_RX:OP_P]}) begin
         qcnt = 2'd1;
      end else if (req_op inside {OP_CCX, OP_CSWAP}) begin
         qcnt = 2'd3;
      end else begin
         qcnt = 2'd2;
      end

      chk = ST_OK;
      if (!ready_ff) begin
         chk = ST_NOT_RESET;
      end else if (req_op > OP_CP) begin
         chk = ST_UNSUP;
      end else if (req_op == OP_READ) begin
         if (32'(req_amp_index) >= 32'(dim)) begin
            chk = ST_RANGE;
         end
      end else if (req_op == OP_MCX) begin
         if (req_control_set == '0) begin
            chk = ST_NO_CTRL;
         end else if ((req_control_set >> n_used) != '0) begin
            chk = ST_RANGE;
         end else if (6'(req_qubit_c) >= 6'(n_used)) begin
            chk = ST_RANGE;
         end else if (cset_qc) begin
            chk = ST_REPEAT;
         end
      end else begin
         if (6'(req_qubit_a) >= 6'(n_used)) begin
            chk = ST_RANGE;
         end else if (qcnt != 2'd1 && 6'(req_qubit_b) >= 6'(n_used)) begin
            chk = ST_RANGE;
         end else if (qcnt != 2'd1 && req_qubit_b == req_qubit_a) begin
            chk = ST_REPEAT;
         end else if (qcnt == 2'd3 && 6'(req_qubit_c) >= 6'(n_used)) begin
            chk = ST_RANGE;
         end else if (qcnt == 2'd3 &&
                      (req_qubit_c == req_qubit_a || req_qubit_c == req_qubit_b)) begin
            chk = ST_REPEAT;
         end
      end

      // identity, then per gate
      for (int i = 0; i < 4; i++) begin
         g_re[i] = COEF_ZERO;
         g_im[i] = COEF_ZERO;
      end
      g_re[0]  = COEF_ONE;
      g_re[3]  = COEF_ONE;
      t_bit    = a_bit;
      g_ctrl   = '0;
      use_swap = 1'b0;
      g_z      = '0;
      g_o      = '0;
      g_flip   = '0;
      case (req_op)
         OP_H: begin
            g_re[0] = COEF_HR; g_re[1] = COEF_HR; g_re[2] = COEF_HR; g_re[3] = -COEF_HR;
         end
         OP_X: begin
            g_re[0] = COEF_ZERO; g_re[1] = COEF_ONE; g_re[2] = COEF_ONE; g_re[3] = COEF_ZERO;
         end
         OP_Y: begin
            g_re[0] = COEF_ZERO; g_im[1] = -COEF_ONE; g_im[2] = COEF_ONE; g_re[3] = COEF_ZERO;
         end
         OP_Z:   g_re[3] = -COEF_ONE;
         OP_S:   begin g_re[3] = COEF_ZERO; g_im[3] = COEF_ONE;  end
         OP_SDG: begin g_re[3] = COEF_ZERO; g_im[3] = -COEF_ONE; end
         OP_T:   begin g_re[3] = COEF_HR;   g_im[3] = COEF_HR;   end
         OP_TDG: begin g_re[3] = COEF_HR;   g_im[3] = -COEF_HR;  end
         OP_CX, OP_CCX, OP_MCX, OP_SWAP, OP_CSWAP: begin
            g_re[0] = COEF_ZERO; g_re[1] = COEF_ONE; g_re[2] = COEF_ONE; g_re[3] = COEF_ZERO;
         end
         OP_CZ:  g_re[3] = -COEF_ONE;
         default: begin
         end
      endcase
      case (req_op)
         OP_CX, OP_CZ, OP_CRX, OP_CRY, OP_CRZ, OP_CP: begin
            t_bit  = b_bit;
            g_ctrl = a_bit;
         end
         OP_CCX: begin
            t_bit  = c_bit;
            g_ctrl = a_bit | b_bit;
         end
         OP_MCX: begin
            t_bit  = c_bit;
            g_ctrl = ADDR_W'(req_control_set);
         end
         OP_SWAP: begin
            use_swap = 1'b1;
            g_z      = a_bit;
            g_o      = b_bit;
         end
         OP_CSWAP: begin
            use_swap = 1'b1;
            g_z      = b_bit;
            g_o      = c_bit;
            g_ctrl   = a_bit;
         end
         default: begin
         end
      endcase
      if (use_swap) begin
         g_flip = g_z | g_o;
      end else begin
         g_z    = t_bit;
         g_flip = t_bit;
      end
   end

   // mix operand selection: component 0/1 is re/im of the low entry, 2/3 of the high one
   always_comb begin
      r0   = a0_ff[DW-1:AMP_BITS];
      i0   = a0_ff[AMP_BITS-1:0];
      r1   = a1_ff[DW-1:AMP_BITS];
      i1   = a1_ff[AMP_BITS-1:0];
      row0 = {cnt_ff[1], 1'b0};
      row1 = {cnt_ff[1], 1'b1};
      if (!cnt_ff[0]) begin
         mix_coef[0] = cre_ff[row0];  mix_opr[0] = r0;
         mix_coef[1] = -cim_ff[row0]; mix_opr[1] = i0;
         mix_coef[2] = cre_ff[row1];  mix_opr[2] = r1;
         mix_coef[3] = -cim_ff[row1]; mix_opr[3] = i1;
      end else begin
         mix_coef[0] = cre_ff[row0];  mix_opr[0] = i0;
         mix_coef[1] = cim_ff[row0];  mix_opr[1] = r0;
         mix_coef[2] = cre_ff[row1];  mix_opr[2] = i1;
         mix_coef[3] = cim_ff[row1];  mix_opr[3] = r1;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      aidx_in       = aidx_ff;
      status_in     = status_ff;
      ready_in      = ready_ff;
      qcount_in     = qcount_ff;
      ctrl_in       = ctrl_ff;
      zmask_in      = zmask_ff;
      omask_in      = omask_ff;
      flip_in       = flip_ff;
      cre_in        = cre_ff;
      cim_in        = cim_ff;
      a0_in         = a0_ff;
      a1_in         = a1_ff;
      res_in        = res_ff;
      out_re_in     = out_re_ff;
      out_im_in     = out_im_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_re_in     = rsp_re_ff;
      rsp_im_in     = rsp_im_ff;

      ram_we       = 1'b0;
      ram_waddr    = kq;
      ram_wdata    = '0;
      ram_raddr    = kq;
      cordic_start = 1'b0;
      cordic_turn  = (req_op inside {OP_P, OP_CP}) ? {req_angle[30:0], 1'b0} : req_angle;

      if (csr_wr_en) begin
         qcount_in = csr_wr_data;
         ready_in  = 1'b0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               aidx_in   = req_amp_index;
               k_in      = '0;
               out_re_in = '0;
               out_im_in = '0;
               status_in = chk;
               ctrl_in   = g_ctrl;
               zmask_in  = g_z;
               omask_in  = g_o;
               flip_in   = g_flip;
               cre_in    = g_re;
               cim_in    = g_im;
               if (req_op == OP_RESET) begin
                  status_in = ST_OK;
                  state_in  = S_CLEAR;
               end else if (chk != ST_OK) begin
                  state_in = S_DONE;
               end else if (req_op == OP_READ) begin
                  state_in = S_RDWAIT;
               end else if (is_rot) begin
                  cordic_start = 1'b1;
                  state_in     = S_TRIG;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_CLEAR: begin
            if (k_ff == dim) begin
               ready_in = 1'b1;
               state_in = S_DONE;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = (k_ff == '0) ? {AMP_ONE, AMP_BITS'(0)} : '0;
               k_in      = k_ff + 1'b1;
            end
         end
         S_RDWAIT: begin
            ram_raddr = ADDR_W'(aidx_ff);
            state_in  = S_RDCAP;
         end
         S_RDCAP: begin
            out_re_in = ram_rdata[DW-1:AMP_BITS];
            out_im_in = ram_rdata[AMP_BITS-1:0];
            state_in  = S_DONE;
         end
         S_TRIG: begin
            if (cordic_done) begin
               for (int i = 0; i < 4; i++) begin
                  cre_in[i] = COEF_ZERO;
                  cim_in[i] = COEF_ZERO;
               end
               case (op_ff[1:0])
                  ROT_X: begin
                     cre_in[0] = cos_v; cre_in[3] = cos_v;
                     cim_in[1] = -sin_v; cim_in[2] = -sin_v;
                  end
                  ROT_Y: begin
                     cre_in[0] = cos_v; cre_in[3] = cos_v;
                     cre_in[1] = -sin_v; cre_in[2] = sin_v;
                  end
                  ROT_Z: begin
                     cre_in[0] = cos_v; cim_in[0] = -sin_v;
                     cre_in[3] = cos_v; cim_in[3] = sin_v;
                  end
                  default: begin
                     cre_in[0] = COEF_ONE;
                     cre_in[3] = cos_v; cim_in[3] = sin_v;
                  end
               endcase
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (k_ff == dim) begin
               state_in = S_DONE;
            end else if (pair_hit) begin
               state_in = S_RDJ;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_RDJ: begin
            ram_raddr = jq;
            a0_in     = ram_rdata;
            state_in  = S_LDJ;
         end
         S_LDJ: begin
            a1_in    = ram_rdata;
            cnt_in   = '0;
            state_in = S_MIX;
         end
         S_MIX: begin
            // results come back through the mix unit's product and result registers
            if (cnt_ff >= 3'd2) begin
               res_in[2'(cnt_ff - 3'd2)] = mix_res;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               state_in = S_WRK;
            end
         end
         S_WRK: begin
            ram_we    = 1'b1;
            ram_wdata = {res_ff[0], res_ff[1]};
            state_in  = S_WRJ;
         end
         S_WRJ: begin
            ram_we    = 1'b1;
            ram_waddr = jq;
            ram_wdata = {res_ff[2], res_ff[3]};
            k_in      = k_ff + 1'b1;
            state_in  = S_SCAN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_re_in     = 32'(out_re_ff);
               rsp_im_in     = 32'(out_im_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         qcount_ff    <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         qcount_ff    <= qcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      op_ff         <= op_in;
      aidx_ff       <= aidx_in;
      status_ff     <= status_in;
      ctrl_ff       <= ctrl_in;
      zmask_ff      <= zmask_in;
      omask_ff      <= omask_in;
      flip_ff       <= flip_in;
      cre_ff        <= cre_in;
      cim_ff        <= cim_in;
      a0_ff         <= a0_in;
      a1_ff         <= a1_in;
      res_ff        <= res_in;
      out_re_ff     <= out_re_in;
      out_im_ff     <= out_im_in;
      rsp_status_ff <= rsp_status_in;
      rsp_re_ff     <= rsp_re_in;
      rsp_im_ff     <= rsp_im_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_amp_real = rsp_re_ff;
   assign rsp_amp_imag = rsp_im_ff;

endmodule

`default_nettype wire

@@ rtl/core/sge_checker.sv @@
// ----------------------------------------------------------------------------
// sge_checker
// Port-level checks of the state-vector gate engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sge_checker
   import sge_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_amp_real,
   input wire logic [31:0] rsp_amp_imag
);

   // no item shows right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_amp_real) && $stable(rsp_amp_imag))
      else $error("stalled result changed");

   // failed commands carry no amplitude
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_amp_real == '0 && rsp_amp_imag == '0)
      else $error("amplitude on error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_NO_CTRL)
      else $error("status code out of range");

endmodule

bind statevector_gate_engine sge_checker u_sge_checker (.*);

`default_nettype wire
